// ===== sv/bsh_pkg.sv =====
package bsh_pkg;

    // Frame and number format
    localparam int WIDTH      = 1024;
    localparam int HEIGHT     = 1024;
    localparam int FRAC_BITS  = 28;
    localparam int COUNT_BITS = 10;

    localparam int NUM_CELLS_DEF = 4;

    // Field widths
    localparam int PIX_W     = 10;
    localparam int CNT_W     = 10;
    localparam int STEP_W    = 31;
    localparam int OFF_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Pixel offset from the center, signed
    localparam int MAX_DIM = (WIDTH > HEIGHT) ? WIDTH : HEIGHT;
    localparam int DW      = ((PIX_W > $clog2(MAX_DIM)) ? PIX_W : $clog2(MAX_DIM)) + 1;
    // offset * step product
    localparam int PW      = DW + STEP_W + 1;
    // c, signed Q4.FRAC_BITS
    localparam int CW      = FRAC_BITS + 4;
    // c before saturation
    localparam int SW      = ((PW > CW) ? PW : CW) + 1;
    // z, never saturated; |z| < 2^(FRAC_BITS+4)
    localparam int ZW      = FRAC_BITS + 5;
    localparam int MAG_W   = ZW - 1;
    // multiplier operand width, magnitude below 2.0
    localparam int MW      = FRAC_BITS + 1;
    // truncated square / cross product
    localparam int SQ_W    = FRAC_BITS + 2;

    localparam logic signed [SW-1:0] C_MAX = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] C_MIN = ~C_MAX;

    localparam logic signed [DW-1:0] HALF_X = DW'(WIDTH / 2);
    localparam logic signed [DW-1:0] HALF_Y = DW'(HEIGHT / 2);

    localparam logic [CNT_W-1:0] COUNT_MASK = CNT_W'((32'd1 << COUNT_BITS) - 32'd1);

    // Configuration registers
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RE_STEP,
        REG_IM_STEP,
        REG_RE_OFFSET,
        REG_IM_OFFSET,
        REG_ITER_LIMIT
    } cfg_reg_t;

    localparam logic [STEP_W-1:0] RE_STEP_RST    = STEP_W'(1048576);
    localparam logic [STEP_W-1:0] IM_STEP_RST    = STEP_W'(1048576);
    localparam logic [OFF_W-1:0]  RE_OFFSET_RST  = '0;
    localparam logic [OFF_W-1:0]  IM_OFFSET_RST  = '0;
    localparam logic [CNT_W-1:0]  ITER_LIMIT_RST = CNT_W'(100);

    // Pixel state travelling around the ring
    typedef struct packed {
        logic                    valid;
        logic                    done;
        logic signed [ZW-1:0]    re;
        logic signed [ZW-1:0]    im;
        logic signed [CW-1:0]    c_re;
        logic signed [CW-1:0]    c_im;
        logic        [CNT_W-1:0] count;
    } bsh_tok_t;

    // Inside a cell, after the multipliers
    typedef struct packed {
        logic                    valid;
        logic                    done;
        logic                    stop;
        logic        [SQ_W-1:0]  re2;
        logic        [SQ_W-1:0]  im2;
        logic        [SQ_W-1:0]  ri;
        logic signed [CW-1:0]    c_re;
        logic signed [CW-1:0]    c_im;
        logic        [CNT_W-1:0] count;
    } bsh_mid_t;

endpackage

// ===== sv/bsh_cell.sv =====
// One Burning Ship iteration in two register stages: products, then update.
module bsh_cell import bsh_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] iter_limit,
    input  bsh_tok_t         tok_i,
    output bsh_tok_t         tok_o
);

    bsh_mid_t mid_reg, mid_next;
    bsh_tok_t tok_reg, tok_next;

    logic signed [ZW-1:0]   neg_re, neg_im;
    logic [MAG_W-1:0]       mr, mi;
    logic [2*MW-1:0]        p_rr, p_ii, p_ri;
    logic [SQ_W:0]          sq_sum;
    logic signed [ZW-1:0]   next_re, next_im;

    // stage A: magnitudes and truncated products
    always_comb begin
        neg_re = -tok_i.re;
        neg_im = -tok_i.im;
        mr = tok_i.re[ZW-1] ? neg_re[MAG_W-1:0] : tok_i.re[MAG_W-1:0];
        mi = tok_i.im[ZW-1] ? neg_im[MAG_W-1:0] : tok_i.im[MAG_W-1:0];
        p_rr = mr[MW-1:0] * mr[MW-1:0];
        p_ii = mi[MW-1:0] * mi[MW-1:0];
        p_ri = mr[MW-1:0] * mi[MW-1:0];

        mid_next.valid = tok_i.valid;
        mid_next.done  = tok_i.done;
        // |re| or |im| at 2.0 or above, or limit reached
        mid_next.stop  = (|mr[MAG_W-1:MW]) || (|mi[MAG_W-1:MW]) ||
                         (tok_i.count >= iter_limit);
        mid_next.re2   = p_rr[2*MW-1:FRAC_BITS];
        mid_next.im2   = p_ii[2*MW-1:FRAC_BITS];
        mid_next.ri    = p_ri[2*MW-1:FRAC_BITS];
        mid_next.c_re  = tok_i.c_re;
        mid_next.c_im  = tok_i.c_im;
        mid_next.count = tok_i.count;
    end

    // stage B: escape test and z update
    always_comb begin
        sq_sum  = {1'b0, mid_reg.re2} + {1'b0, mid_reg.im2};
        next_re = $signed({{(ZW-SQ_W){1'b0}}, mid_reg.re2})
                - $signed({{(ZW-SQ_W){1'b0}}, mid_reg.im2})
                + ZW'(mid_reg.c_re);
        next_im = $signed({{(ZW-SQ_W-1){1'b0}}, mid_reg.ri, 1'b0})
                + ZW'(mid_reg.c_im);

        tok_next.valid = mid_reg.valid;
        tok_next.done  = mid_reg.done;
        tok_next.re    = next_re;
        tok_next.im    = next_im;
        tok_next.c_re  = mid_reg.c_re;
        tok_next.c_im  = mid_reg.c_im;
        tok_next.count = mid_reg.count;
        if (!mid_reg.done) begin
            // top bit of the sum set means |z|^2 >= 4
            if (mid_reg.stop || sq_sum[SQ_W]) begin
                tok_next.done = 1'b1;
            end else begin
                tok_next.count = mid_reg.count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg <= '0;
            tok_reg <= '0;
        end else begin
            mid_reg <= mid_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_o = tok_reg;

endmodule

// ===== sv/burning_ship_escape_time.sv =====
// Burning Ship escape-time unit.
// Input channel s_*: one word per pixel (s_pixel_x, s_pixel_y). The pixel is
// mapped to c = (pixel - size/2) * step + offset, saturated to signed Q4.28,
// and the iteration z = (re^2 - im^2 + c_re, |2 re im| + c_im) runs from z = 0.
// Result channel m_*: one word per pixel, iteration count and escape flag.
// Configuration: cfg_wr_en/cfg_index/cfg_data write re_step, im_step,
// re_offset, im_offset, iter_limit (indexes 0..4); other indexes are ignored.
// Write only while no pixel is in flight.
// One pixel is processed at a time. The pixel state circulates through a ring
// of NUM_CELLS iteration cells, one iteration per cell.
// Coordinate mapping registers the products, then the offset and saturation;
// the pixel then enters the ring and goes round until it is done, and the
// word leaving the last cell loads the output register.
// s_ready drops from acceptance until the result word enters the output
// register; the next pixel may then start while that word waits on m_ready.
// A finished pixel blocked by a full output register just goes round again.
// Reset (aresetn low, synchronous) empties the ring and output, and loads the
// register defaults.
module burning_ship_escape_time import bsh_pkg::*; #(
    parameter int NUM_CELLS = NUM_CELLS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_pixel_x,
    input  logic [PIX_W-1:0]     s_pixel_y,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CNT_W-1:0]     m_iteration_count,
    output logic                 m_escaped
);

    logic [STEP_W-1:0] re_step_reg, im_step_reg;
    logic [OFF_W-1:0]  re_offset_reg, im_offset_reg;
    logic [CNT_W-1:0]  iter_limit_reg;

    logic                 busy_reg, busy_next;
    logic                 p1_valid_reg, p1_valid_next;
    logic signed [PW-1:0] prod_re_reg, prod_re_next, prod_im_reg, prod_im_next;
    logic                 p2_valid_reg, p2_valid_next;
    logic signed [CW-1:0] c_re_reg, c_re_next, c_im_reg, c_im_next;

    logic                 m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 escaped_reg, escaped_next;

    logic                 accept;
    logic                 exit_now;
    logic signed [DW-1:0] dx, dy;
    logic signed [SW-1:0] sum_re, sum_im;

    bsh_tok_t ring_in;
    bsh_tok_t wrap_tok;
    bsh_tok_t chain [NUM_CELLS];

    assign accept   = s_valid && s_ready;
    assign s_ready  = !busy_reg;
    assign wrap_tok = chain[NUM_CELLS-1];
    assign exit_now = wrap_tok.valid && wrap_tok.done && (!m_valid_reg || m_ready);

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            re_step_reg    <= RE_STEP_RST;
            im_step_reg    <= IM_STEP_RST;
            re_offset_reg  <= RE_OFFSET_RST;
            im_offset_reg  <= IM_OFFSET_RST;
            iter_limit_reg <= ITER_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_RE_STEP:    re_step_reg    <= cfg_data[STEP_W-1:0];
                REG_IM_STEP:    im_step_reg    <= cfg_data[STEP_W-1:0];
                REG_RE_OFFSET:  re_offset_reg  <= cfg_data[OFF_W-1:0];
                REG_IM_OFFSET:  im_offset_reg  <= cfg_data[OFF_W-1:0];
                REG_ITER_LIMIT: iter_limit_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // coordinate mapping: products, then offset and saturation
    always_comb begin
        dx = $signed(DW'(s_pixel_x)) - HALF_X;
        dy = $signed(DW'(s_pixel_y)) - HALF_Y;
        prod_re_next  = dx * $signed({1'b0, re_step_reg});
        prod_im_next  = dy * $signed({1'b0, im_step_reg});
        p1_valid_next = accept;

        sum_re = SW'(prod_re_reg) + SW'($signed(re_offset_reg));
        sum_im = SW'(prod_im_reg) + SW'($signed(im_offset_reg));
        if (sum_re > C_MAX) begin
            c_re_next = CW'(C_MAX);
        end else if (sum_re < C_MIN) begin
            c_re_next = CW'(C_MIN);
        end else begin
            c_re_next = CW'(sum_re);
        end
        if (sum_im > C_MAX) begin
            c_im_next = CW'(C_MAX);
        end else if (sum_im < C_MIN) begin
            c_im_next = CW'(C_MIN);
        end else begin
            c_im_next = CW'(sum_im);
        end
        p2_valid_next = p1_valid_reg;
    end

    // ring entry: a fresh pixel, or the word coming round from the last cell
    always_comb begin
        if (p2_valid_reg) begin
            ring_in.valid = 1'b1;
            ring_in.done  = 1'b0;
            ring_in.re    = '0;
            ring_in.im    = '0;
            ring_in.c_re  = c_re_reg;
            ring_in.c_im  = c_im_reg;
            ring_in.count = '0;
        end else begin
            ring_in       = wrap_tok;
            ring_in.valid = wrap_tok.valid && !exit_now;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++) begin : g_cell
            if (g == 0) begin : g_first
                bsh_cell u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .iter_limit (iter_limit_reg),
                    .tok_i      (ring_in),
                    .tok_o      (chain[g])
                );
            end else begin : g_next
                bsh_cell u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .iter_limit (iter_limit_reg),
                    .tok_i      (chain[g-1]),
                    .tok_o      (chain[g])
                );
            end
        end
    endgenerate

    // output register and busy flag
    always_comb begin
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        count_next   = count_reg;
        escaped_next = escaped_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (exit_now) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
            count_next   = wrap_tok.count & COUNT_MASK;
            escaped_next = wrap_tok.count < iter_limit_reg;
        end
        if (accept) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        prod_re_reg <= prod_re_next;
        prod_im_reg <= prod_im_next;
        c_re_reg    <= c_re_next;
        c_im_reg    <= c_im_next;
        count_reg   <= count_next;
        escaped_reg <= escaped_next;
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_iteration_count = count_reg;
    assign m_escaped         = escaped_reg;

endmodule

// ===== sv/bsh_checker.sv =====
module bsh_checker import bsh_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [CNT_W-1:0] m_iteration_count,
    input logic             m_escaped
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_iteration_count) && $stable(m_escaped))
        else $error("result word changed or dropped while stalled");

    // one pixel at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second pixel accepted while one is in flight");

    // the unit frees up only by handing a result to the output register
    a_free_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_ready) && $past(aresetn) |-> m_valid)
        else $error("input reopened without a result");

    // z = 0 never escapes, so an escaped pixel ran at least one iteration
    a_escape_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_escaped |-> m_iteration_count != '0)
        else $error("escaped with zero iterations");

endmodule

bind burning_ship_escape_time bsh_checker u_bsh_checker (.*);
